// ----- hdl/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes of the circular deque: data word, operation codes
// and result status codes.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;
    localparam int CNT_W  = 5;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

endpackage

// ----- hdl/cdq_cell.sv -----
// ----------------------------------------------------------------------------
// cdq_cell
// One storage cell of the deque row. Holds one entry, takes a broadcast write
// that matches its position, and forwards the read link to its neighbor,
// substituting its own entry when the link asks for its position.
// ----------------------------------------------------------------------------
module cdq_cell #(
    parameter int IW    = 4,
    parameter int INDEX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  logic [IW-1:0]  i_wr_idx,
    input  cdq_pkg::t_data i_wr_data,
    input  logic           i_lnk_vld,
    input  logic [IW-1:0]  i_lnk_idx,
    input  cdq_pkg::t_data i_lnk_data,
    output logic           o_lnk_vld,
    output logic [IW-1:0]  o_lnk_idx,
    output cdq_pkg::t_data o_lnk_data
);

    cdq_pkg::t_data r_entry;
    logic           r_lnk_vld;
    logic [IW-1:0]  r_lnk_idx;
    cdq_pkg::t_data r_lnk_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lnk_vld <= 1'b0;
        end else begin
            r_lnk_vld <= i_lnk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == IW'(INDEX))) begin
            r_entry <= i_wr_data;
        end
        r_lnk_idx  <= i_lnk_idx;
        r_lnk_data <= (i_lnk_idx == IW'(INDEX)) ? r_entry : i_lnk_data;
    end

    assign o_lnk_vld  = r_lnk_vld;
    assign o_lnk_idx  = r_lnk_idx;
    assign o_lnk_data = r_lnk_data;

endmodule

// ----- hdl/circular_deque.sv -----
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a row of DEPTH storage cells with wrapping head and
// tail pointers; push or pop at either end, one result per operation.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A push, a refused operation, or a pop that
// empties the deque shows its result in the cycle after the input transfer. A
// pop that leaves values behind must fetch the new front or rear entry: the
// read request is registered and walks the row of DEPTH cells one cell per
// cycle, and the entry it returns becomes the new front or rear value with
// the result. The next input is taken in the cycle in which the result is
// transferred. Writes to the capacity register are taken at any time but
// belong in idle periods; the capacity is clamped to the range 1 to DEPTH.
module circular_deque #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [cdq_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_mode,
    input  cdq_pkg::t_data             i_item_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output cdq_pkg::t_data             o_front_value,
    output cdq_pkg::t_data             o_rear_value,
    output logic [cdq_pkg::CNT_W-1:0]  o_entry_count,
    output logic                       o_is_empty,
    output logic                       o_is_full
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (IW + 1 > CW) ? IW + 1 : CW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic [cdq_pkg::CFG_W-1:0]   r_cfg;
    logic [IW-1:0]               r_head, n_head;
    logic [IW-1:0]               r_tail, n_tail;
    logic [CW-1:0]               r_count, n_count;
    cdq_pkg::t_data              r_front, n_front;
    cdq_pkg::t_data              r_rear, n_rear;
    cdq_pkg::t_status            r_status, n_status;
    logic                        r_full, n_full;
    logic                        r_rd_front, n_rd_front;
    logic                        r_q_vld, n_q_vld;
    logic [IW-1:0]               r_q_idx, n_q_idx;

    logic                        wr_en;
    logic [IW-1:0]               wr_idx;
    logic [CW-1:0]               cap;
    logic                        in_xfer;
    logic [IW-1:0]               step_ptr;

    logic                        lnk_vld  [DEPTH+1];
    logic [IW-1:0]               lnk_idx  [DEPTH+1];
    cdq_pkg::t_data              lnk_data [DEPTH+1];

    function automatic logic [IW-1:0] step_up(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] c);
        logic [IW:0] nxt;
        nxt = {1'b0, idx} + (IW+1)'(1);
        return (SW'(nxt) >= SW'(c)) ? '0 : nxt[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] step_down(input logic [IW-1:0] idx,
                                                input logic [CW-1:0] c);
        return (idx == '0) ? IW'(c - CW'(1)) : idx - IW'(1);
    endfunction

    always_comb begin
        if (r_cfg == '0) begin
            cap = CW'(1);
        end else if (int'(r_cfg) > DEPTH) begin
            cap = CW'(DEPTH);
        end else begin
            cap = CW'(r_cfg);
        end
    end

    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_DONE) && i_out_ready);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_front    = r_front;
        n_rear     = r_rear;
        n_status   = r_status;
        n_full     = r_full;
        n_rd_front = r_rd_front;
        n_q_vld    = 1'b0;
        n_q_idx    = r_q_idx;
        wr_en      = 1'b0;
        wr_idx     = '0;
        step_ptr   = '0;

        if (in_xfer) begin
            n_status = cdq_pkg::STAT_DONE;
            n_state  = S_DONE;
            unique case (cdq_pkg::t_mode'(i_mode))
                cdq_pkg::MODE_PUSH_FRONT, cdq_pkg::MODE_PUSH_REAR: begin
                    if (r_count >= cap) begin
                        n_status = cdq_pkg::STAT_FULL;
                    end else if (r_count == '0) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = CW'(1);
                        n_front = i_item_value;
                        n_rear  = i_item_value;
                        wr_en   = 1'b1;
                        wr_idx  = '0;
                    end else if (cdq_pkg::t_mode'(i_mode) == cdq_pkg::MODE_PUSH_FRONT) begin
                        step_ptr = step_down(r_head, cap);
                        n_head   = step_ptr;
                        n_count  = r_count + CW'(1);
                        n_front  = i_item_value;
                        if (r_tail == step_ptr) begin
                            n_rear = i_item_value;
                        end
                        wr_en  = 1'b1;
                        wr_idx = step_ptr;
                    end else begin
                        step_ptr = step_up(r_tail, cap);
                        n_tail   = step_ptr;
                        n_count  = r_count + CW'(1);
                        n_rear   = i_item_value;
                        if (r_head == step_ptr) begin
                            n_front = i_item_value;
                        end
                        wr_en  = 1'b1;
                        wr_idx = step_ptr;
                    end
                end
                cdq_pkg::MODE_POP_FRONT, cdq_pkg::MODE_POP_REAR: begin
                    if (r_count == '0) begin
                        n_status = cdq_pkg::STAT_EMPTY;
                    end else if (r_count == CW'(1)) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                    end else if (cdq_pkg::t_mode'(i_mode) == cdq_pkg::MODE_POP_FRONT) begin
                        step_ptr   = step_up(r_head, cap);
                        n_head     = step_ptr;
                        n_count    = r_count - CW'(1);
                        n_q_vld    = 1'b1;
                        n_q_idx    = step_ptr;
                        n_rd_front = 1'b1;
                        n_state    = S_READ;
                    end else begin
                        step_ptr   = step_down(r_tail, cap);
                        n_tail     = step_ptr;
                        n_count    = r_count - CW'(1);
                        n_q_vld    = 1'b1;
                        n_q_idx    = step_ptr;
                        n_rd_front = 1'b0;
                        n_state    = S_READ;
                    end
                end
            endcase
            n_full = (n_count >= cap);
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    n_state = S_IDLE;
                end
                S_READ: begin
                    if (lnk_vld[DEPTH]) begin
                        if (r_rd_front) begin
                            n_front = lnk_data[DEPTH];
                        end else begin
                            n_rear = lnk_data[DEPTH];
                        end
                        n_state = S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_out_ready) begin
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= cdq_pkg::CAP_RESET;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_q_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_q_vld <= n_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front    <= n_front;
        r_rear     <= n_rear;
        r_status   <= n_status;
        r_full     <= n_full;
        r_rd_front <= n_rd_front;
        r_q_idx    <= n_q_idx;
    end

    assign lnk_vld[0]  = r_q_vld;
    assign lnk_idx[0]  = r_q_idx;
    assign lnk_data[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        cdq_cell #(
            .IW    (IW),
            .INDEX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (wr_en),
            .i_wr_idx   (wr_idx),
            .i_wr_data  (i_item_value),
            .i_lnk_vld  (lnk_vld[g]),
            .i_lnk_idx  (lnk_idx[g]),
            .i_lnk_data (lnk_data[g]),
            .o_lnk_vld  (lnk_vld[g+1]),
            .o_lnk_idx  (lnk_idx[g+1]),
            .o_lnk_data (lnk_data[g+1])
        );
    end

    assign o_out_valid   = (r_state == S_DONE);
    assign o_status      = r_status;
    assign o_front_value = (r_count == '0) ? '0 : r_front;
    assign o_rear_value  = (r_count == '0) ? '0 : r_rear;
    assign o_entry_count = cdq_pkg::CNT_W'(r_count);
    assign o_is_empty    = (r_count == '0);
    assign o_is_full     = r_full;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= DEPTH)
        else $error("count exceeds depth");

    a_link_only_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lnk_vld[DEPTH] |-> (r_state == S_READ))
        else $error("read link returned outside read state");

    a_read_has_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_count != '0))
        else $error("fetch pending on empty deque");

    a_refused_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (n_status != cdq_pkg::STAT_DONE)) |=> $stable(r_count))
        else $error("refused operation changed count");

    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_vld |=> !r_q_vld)
        else $error("read request held longer than one cycle");
`endif

endmodule

// ----- sim/circular_deque_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// Self-checking bench for the circular deque. A queue of pending operations
// feeds a valid/ready driver. Each accepted transfer runs through a local
// deque model that tracks the store, both pointers, the count and the
// capacity. A monitor compares every result transfer field by field against
// the oldest prediction. The run is a directed opening that fills the store,
// overflows it and wraps the head, followed by randomized push/pop runs over
// a range of capacity settings: clamped values, settings below the current
// count, and a stretch with no idle cycles on either side.
// ----------------------------------------------------------------------------
module circular_deque_tb;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_OPS   = 96;

    typedef struct {
        cdq_pkg::t_mode mode;
        cdq_pkg::t_data value;
    } t_deque_op;

    typedef struct {
        cdq_pkg::t_status          status;
        cdq_pkg::t_data            front;
        cdq_pkg::t_data            rear;
        logic [cdq_pkg::CNT_W-1:0] count;
        logic                      empty;
        logic                      full;
    } t_deque_view;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_wr_en   = 1'b0;
    logic [cdq_pkg::CFG_W-1:0] i_cfg_wr_data = '0;
    logic                      i_in_valid    = 1'b0;
    logic [1:0]                i_mode        = cdq_pkg::MODE_PUSH_FRONT;
    cdq_pkg::t_data            i_item_value  = '0;
    logic                      i_out_ready   = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [1:0]                o_status;
    cdq_pkg::t_data            o_front_value;
    cdq_pkg::t_data            o_rear_value;
    logic [cdq_pkg::CNT_W-1:0] o_entry_count;
    logic                      o_is_empty;
    logic                      o_is_full;

    t_deque_op   pending_ops[$];
    t_deque_view due_views[$];
    t_deque_op   next_op;
    t_deque_view seen_view;

    cdq_pkg::t_data            dq_store[DEPTH];
    int unsigned               dq_head;
    int unsigned               dq_tail;
    int unsigned               dq_count;
    logic [cdq_pkg::CFG_W-1:0] cap_reg;

    int valid_idle_pct = 33;
    int ready_idle_pct = 33;
    int cycle_count    = 0;
    int error_count    = 0;
    int checked_count  = 0;
    int full_refusals  = 0;
    int empty_refusals = 0;
    int cap_writes     = 0;

    circular_deque #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, due_views.size());
            $display("circular_deque_tb: FAIL");
            $finish;
        end
    end

    function automatic int unsigned wrap_up(int unsigned idx, int unsigned cap);
        int unsigned n;
        n = idx + 1;
        return ((n >= cap) ? 0 : n) % DEPTH;
    endfunction

    function automatic int unsigned wrap_down(int unsigned idx, int unsigned cap);
        return ((idx == 0) ? cap - 1 : idx - 1) % DEPTH;
    endfunction

    function automatic t_deque_view apply_deque_op(cdq_pkg::t_mode m, cdq_pkg::t_data v);
        t_deque_view r;
        int unsigned cap;
        cap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
        r.status = cdq_pkg::STAT_DONE;
        if (m == cdq_pkg::MODE_PUSH_FRONT || m == cdq_pkg::MODE_PUSH_REAR) begin
            if (dq_count >= cap) begin
                r.status = cdq_pkg::STAT_FULL;
                full_refusals++;
            end else if (dq_count == 0) begin
                dq_head = 0;
                dq_tail = 0;
                dq_store[0] = v;
                dq_count = 1;
            end else if (m == cdq_pkg::MODE_PUSH_FRONT) begin
                dq_head = wrap_down(dq_head, cap);
                dq_store[dq_head] = v;
                dq_count++;
            end else begin
                dq_tail = wrap_up(dq_tail, cap);
                dq_store[dq_tail] = v;
                dq_count++;
            end
        end else begin
            if (dq_count == 0) begin
                r.status = cdq_pkg::STAT_EMPTY;
                empty_refusals++;
            end else if (dq_count == 1) begin
                dq_head = 0;
                dq_tail = 0;
                dq_count = 0;
            end else if (m == cdq_pkg::MODE_POP_FRONT) begin
                dq_head = wrap_up(dq_head, cap);
                dq_count--;
            end else begin
                dq_tail = wrap_down(dq_tail, cap);
                dq_count--;
            end
        end
        r.empty = (dq_count == 0);
        r.front = r.empty ? '0 : dq_store[dq_head];
        r.rear  = r.empty ? '0 : dq_store[dq_tail];
        r.count = dq_count[cdq_pkg::CNT_W-1:0];
        r.full  = (dq_count >= cap);
        return r;
    endfunction

    // driver: present the next pending op once the current one transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                due_views.push_back(apply_deque_op(cdq_pkg::t_mode'(i_mode), i_item_value));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= valid_idle_pct) begin
                    next_op = pending_ops.pop_front();
                    i_in_valid   <= 1'b1;
                    i_mode       <= next_op.mode;
                    i_item_value <= next_op.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= ready_idle_pct);
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, name, want, got);
            error_count++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_views.size() == 0) begin
                $display("%0t: result transfer with nothing expected", $time);
                error_count++;
            end else begin
                seen_view = due_views.pop_front();
                checked_count++;
                check_field("status", seen_view.status, o_status);
                check_field("front_value", seen_view.front, o_front_value);
                check_field("rear_value", seen_view.rear, o_rear_value);
                check_field("entry_count", seen_view.count, o_entry_count);
                check_field("is_empty", seen_view.empty, o_is_empty);
                check_field("is_full", seen_view.full, o_is_full);
            end
        end
    end

    function automatic cdq_pkg::t_data pick_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'sh8000_0000;
            3:       return 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(cdq_pkg::t_mode m, cdq_pkg::t_data v);
        t_deque_op op;
        op.mode  = m;
        op.value = v;
        pending_ops.push_back(op);
    endtask

    // push-heavy, pop-heavy and balanced runs so the deque fills and drains
    task automatic queue_phase(int n);
        int left;
        int run;
        int push_pct;
        left = n;
        while (left > 0) begin
            run = $urandom_range(20, 4);
            if (run > left) begin
                run = left;
            end
            case ($urandom_range(2))
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            repeat (run) begin
                if ($urandom_range(99) < push_pct) begin
                    add_op($urandom_range(1) ? cdq_pkg::MODE_PUSH_REAR
                                             : cdq_pkg::MODE_PUSH_FRONT,
                           pick_value());
                end else begin
                    add_op($urandom_range(1) ? cdq_pkg::MODE_POP_REAR
                                             : cdq_pkg::MODE_POP_FRONT,
                           pick_value());
                end
            end
            left -= run;
        end
    endtask

    // hold the sender until every result has transferred, then let it settle
    task automatic drain_results();
        while (pending_ops.size() != 0 || i_in_valid || due_views.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [cdq_pkg::CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        cap_reg = v;
        cap_writes++;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [cdq_pkg::CFG_W-1:0] caps[12];
        caps = '{5'd3, 5'd0, 5'd31, 5'd1, 5'd2, 5'd9,
                 5'd16, 5'd4, 5'd17, 5'd15, 5'd5, 5'd16};
        dq_head  = 0;
        dq_tail  = 0;
        dq_count = 0;
        cap_reg  = cdq_pkg::CAP_RESET;
        foreach (dq_store[k]) begin
            dq_store[k] = '0;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_capacity(5'd16);

        add_op(cdq_pkg::MODE_POP_FRONT, '1);
        add_op(cdq_pkg::MODE_POP_REAR, 32'sh8000_0000);
        add_op(cdq_pkg::MODE_PUSH_FRONT, 32'sh8000_0000);
        add_op(cdq_pkg::MODE_PUSH_REAR, 32'sh7fff_ffff);
        add_op(cdq_pkg::MODE_PUSH_REAR, '1);
        add_op(cdq_pkg::MODE_PUSH_REAR, '0);
        repeat (12) add_op(cdq_pkg::MODE_PUSH_REAR, $urandom);
        add_op(cdq_pkg::MODE_PUSH_FRONT, 32'sh1234_5678);
        add_op(cdq_pkg::MODE_PUSH_REAR, 32'sh0bad_cafe);
        add_op(cdq_pkg::MODE_POP_FRONT, '0);
        add_op(cdq_pkg::MODE_POP_REAR, '0);
        add_op(cdq_pkg::MODE_PUSH_FRONT, 32'sh5a5a_5a5a);
        add_op(cdq_pkg::MODE_PUSH_FRONT, 32'sha5a5_a5a5);
        add_op(cdq_pkg::MODE_POP_FRONT, '0);
        drain_results();

        foreach (caps[p]) begin
            write_capacity(caps[p]);
            if (p == 6) begin
                valid_idle_pct = 0;
                ready_idle_pct = 0;
            end else begin
                valid_idle_pct = 33;
                ready_idle_pct = 33;
            end
            queue_phase(PHASE_OPS);
            drain_results();
        end

        $display("Checked %0d result transfers across %0d capacity writes;", checked_count,
                 cap_writes);
        $display("refused pushes when full: %0d, refused pops when empty: %0d.",
                 full_refusals, empty_refusals);
        if (error_count == 0) begin
            $display("circular_deque_tb: PASS");
        end else begin
            $display("circular_deque_tb: FAIL");
        end
        $finish;
    end

endmodule
